### hw/rtl/afp_pkg.sv
// Shared types, codes and helper functions for the escape frame parser.
// No dependencies; used by every module of the block.
package afp_pkg;

  localparam int LINE_MAX_DEF     = 256;
  localparam int LEN_DIGITS_DEF   = 4;
  localparam int RESULT_DEPTH_DEF = 8;
  localparam logic [7:0] ESCAPE_RESET = 8'd27;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_LBYTE   = 3'd1;
  localparam logic [2:0] KIND_LEND    = 3'd2;
  localparam logic [2:0] KIND_LABORT  = 3'd3;
  localparam logic [2:0] KIND_EVENT   = 3'd4;

  localparam logic [2:0] FT_STREAM = 3'd0;
  localparam logic [2:0] FT_BULK   = 3'd1;
  localparam logic [2:0] FT_HTTP   = 3'd2;
  localparam logic [2:0] FT_UDPB   = 3'd3;
  localparam logic [2:0] FT_UDP    = 3'd4;
  localparam logic [2:0] FT_NONE   = 3'd7;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_STREAM = 3'd1;
  localparam logic [2:0] EV_BULK   = 3'd2;
  localparam logic [2:0] EV_HTTP   = 3'd3;
  localparam logic [2:0] EV_OK     = 3'd4;
  localparam logic [2:0] EV_FAIL   = 3'd5;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_U_LO  = 8'h75;
  localparam logic [7:0] CH_U_UP  = 8'h55;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_E     = 8'h45;

  typedef enum logic [8:0] {
    ST_START    = 9'b000000001,
    ST_LINE     = 9'b000000010,
    ST_ESC      = 9'b000000100,
    ST_CID      = 9'b000001000,
    ST_LEN      = 9'b000010000,
    ST_ADDR     = 9'b000100000,
    ST_PORT     = 9'b001000000,
    ST_DATA_LEN = 9'b010000000,
    ST_DATA_ESC = 9'b100000000
  } parse_state_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [2:0] frame_type;
    logic [4:0] channel_id;
    logic [7:0] data_byte;
    logic [7:0] line_length;
    logic [2:0] event_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t make_result(logic [2:0] kind, logic [2:0] ft,
                                          logic [4:0] ch, logic [7:0] data,
                                          logic [7:0] len, logic [2:0] ev);
    result_t r;
    r.result_kind = kind;
    r.frame_type  = ft;
    r.channel_id  = ch;
    r.data_byte   = data;
    r.line_length = len;
    r.event_code  = ev;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

  function automatic logic [2:0] done_code(logic [2:0] kind);
    logic [2:0] ev;
    if (kind == FT_STREAM) begin
      ev = EV_STREAM;
    end else if (kind == FT_HTTP) begin
      ev = EV_HTTP;
    end else begin
      ev = EV_BULK;
    end
    return ev;
  endfunction

endpackage

### hw/rtl/afp_parser.sv
// Parse state machine: takes one registered byte per cycle while item_valid is high and produces up to two results.
// Depends on afp_pkg.
module afp_parser import afp_pkg::*; #(
  parameter int LINE_MAX   = LINE_MAX_DEF,
  parameter int LEN_DIGITS = LEN_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [7:0] item_byte,
  input  logic [7:0] escape_byte,
  output push_t      push
);

  parse_state_t parse_state, parse_state_next;
  logic [7:0]   line_count, line_count_next;
  logic [4:0]   frame_channel, frame_channel_next;
  logic [2:0]   frame_kind, frame_kind_next;
  logic [13:0]  expected_length, expected_length_next;
  logic [13:0]  received_count, received_count_next;
  logic [2:0]   digit_index, digit_index_next;
  logic         escape_pending, escape_pending_next;

  logic [13:0] len_sum;
  logic [2:0]  digit_inc;
  logic [13:0] count_inc;
  logic [8:0]  line_inc;
  push_t       res;

  assign len_sum   = 14'((expected_length << 3) + (expected_length << 1)
                         + 14'(item_byte - 8'h30));
  assign digit_inc = digit_index + 3'd1;
  assign count_inc = received_count + 14'd1;
  assign line_inc  = {1'b0, line_count} + 9'd1;

  always_comb begin
    parse_state_next     = parse_state;
    line_count_next      = line_count;
    frame_channel_next   = frame_channel;
    frame_kind_next      = frame_kind;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    digit_index_next     = digit_index;
    escape_pending_next  = escape_pending;
    res                  = '0;

    unique case (parse_state)
      ST_START: begin
        if (item_byte == CH_CR || item_byte == CH_LF || item_byte == CH_NUL) begin
          parse_state_next = ST_START;
        end else if (item_byte == escape_byte) begin
          parse_state_next = ST_ESC;
        end else begin
          line_count_next  = 8'd1;
          parse_state_next = ST_LINE;
          res.count = 2'd1;
          res.first = make_result(KIND_LBYTE, 3'd0, 5'd0, item_byte, 8'd0, EV_NONE);
        end
      end
      ST_LINE: begin
        if (item_byte == escape_byte) begin
          res.count = 2'd1;
          res.first = make_result(KIND_LABORT, 3'd0, 5'd0, 8'd0, line_count, EV_NONE);
          line_count_next  = 8'd0;
          parse_state_next = ST_ESC;
        end else if (item_byte == CH_CR || item_byte == CH_LF) begin
          res.count = 2'd1;
          res.first = make_result(KIND_LEND, 3'd0, 5'd0, 8'd0, line_count, EV_NONE);
          line_count_next  = 8'd0;
          parse_state_next = ST_START;
        end else if (line_inc < 9'(LINE_MAX)) begin
          line_count_next = line_inc[7:0];
          res.count = 2'd1;
          res.first = make_result(KIND_LBYTE, 3'd0, 5'd0, item_byte, 8'd0, EV_NONE);
        end
      end
      ST_ESC: begin
        parse_state_next     = ST_CID;
        digit_index_next     = 3'd0;
        expected_length_next = 14'd0;
        received_count_next  = 14'd0;
        escape_pending_next  = 1'b0;
        if (item_byte == CH_Z) begin
          frame_kind_next = FT_BULK;
        end else if (item_byte == CH_H) begin
          frame_kind_next = FT_HTTP;
        end else if (item_byte == CH_S) begin
          frame_kind_next = FT_STREAM;
        end else if (item_byte == CH_Y) begin
          frame_kind_next = FT_UDPB;
        end else if (item_byte == CH_U_LO || item_byte == CH_U_UP) begin
          frame_kind_next = FT_UDP;
        end else begin
          parse_state_next = ST_START;
          line_count_next  = 8'd0;
          frame_kind_next  = FT_NONE;
          if (item_byte == CH_O) begin
            res.count = 2'd1;
            res.first = make_result(KIND_EVENT, 3'd0, 5'd0, 8'd0, 8'd0, EV_OK);
          end else if (item_byte == CH_F) begin
            res.count = 2'd1;
            res.first = make_result(KIND_EVENT, 3'd0, 5'd0, 8'd0, 8'd0, EV_FAIL);
          end
        end
      end
      ST_CID: begin
        frame_channel_next   = hex_value(item_byte);
        digit_index_next     = 3'd0;
        expected_length_next = 14'd0;
        escape_pending_next  = 1'b0;
        if (frame_kind == FT_STREAM) begin
          parse_state_next = ST_DATA_ESC;
        end else if (frame_kind == FT_UDPB || frame_kind == FT_UDP) begin
          parse_state_next = ST_ADDR;
        end else begin
          parse_state_next = ST_LEN;
        end
      end
      ST_ADDR: begin
        if (item_byte == CH_SPACE) begin
          parse_state_next = ST_PORT;
        end
      end
      ST_PORT: begin
        if (item_byte == CH_TAB) begin
          digit_index_next     = 3'd0;
          expected_length_next = 14'd0;
          escape_pending_next  = 1'b0;
          parse_state_next     = (frame_kind == FT_UDP) ? ST_DATA_ESC : ST_LEN;
        end
      end
      ST_LEN: begin
        if (item_byte < 8'h30 || item_byte > 8'h39) begin
          parse_state_next     = ST_START;
          line_count_next      = 8'd0;
          expected_length_next = 14'd0;
          received_count_next  = 14'd0;
          digit_index_next     = 3'd0;
          escape_pending_next  = 1'b0;
          frame_kind_next      = FT_NONE;
        end else begin
          expected_length_next = len_sum;
          digit_index_next     = digit_inc;
          if (digit_inc >= 3'(LEN_DIGITS)) begin
            received_count_next = 14'd0;
            if (len_sum == 14'd0) begin
              res.count = 2'd1;
              res.first = make_result(KIND_EVENT, frame_kind, frame_channel, 8'd0, 8'd0,
                                      done_code(frame_kind));
              parse_state_next     = ST_START;
              line_count_next      = 8'd0;
              expected_length_next = 14'd0;
              digit_index_next     = 3'd0;
              escape_pending_next  = 1'b0;
              frame_kind_next      = FT_NONE;
            end else begin
              parse_state_next = ST_DATA_LEN;
            end
          end
        end
      end
      ST_DATA_LEN: begin
        res.count = 2'd1;
        res.first = make_result(KIND_PAYLOAD, frame_kind, frame_channel, item_byte, 8'd0,
                                EV_NONE);
        received_count_next = count_inc;
        if (count_inc >= expected_length) begin
          res.count  = 2'd2;
          res.second = make_result(KIND_EVENT, frame_kind, frame_channel, 8'd0, 8'd0,
                                   done_code(frame_kind));
          parse_state_next     = ST_START;
          line_count_next      = 8'd0;
          expected_length_next = 14'd0;
          received_count_next  = 14'd0;
          digit_index_next     = 3'd0;
          escape_pending_next  = 1'b0;
          frame_kind_next      = FT_NONE;
        end
      end
      ST_DATA_ESC: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (item_byte == CH_E) begin
            res.count = 2'd1;
            res.first = make_result(KIND_EVENT, frame_kind, frame_channel, 8'd0, 8'd0,
                                    done_code(frame_kind));
            parse_state_next     = ST_START;
            line_count_next      = 8'd0;
            expected_length_next = 14'd0;
            received_count_next  = 14'd0;
            digit_index_next     = 3'd0;
            frame_kind_next      = FT_NONE;
          end else begin
            res.count  = 2'd2;
            res.first  = make_result(KIND_PAYLOAD, frame_kind, frame_channel, escape_byte,
                                     8'd0, EV_NONE);
            res.second = make_result(KIND_PAYLOAD, frame_kind, frame_channel, item_byte,
                                     8'd0, EV_NONE);
          end
        end else if (item_byte == escape_byte) begin
          escape_pending_next = 1'b1;
        end else begin
          res.count = 2'd1;
          res.first = make_result(KIND_PAYLOAD, frame_kind, frame_channel, item_byte, 8'd0,
                                  EV_NONE);
        end
      end
      default: begin
        parse_state_next     = ST_START;
        line_count_next      = 8'd0;
        expected_length_next = 14'd0;
        received_count_next  = 14'd0;
        digit_index_next     = 3'd0;
        escape_pending_next  = 1'b0;
        frame_kind_next      = FT_NONE;
      end
    endcase

    if (res.count == 2'd1) begin
      res.first.last = 1'b1;
    end else if (res.count == 2'd2) begin
      res.second.last = 1'b1;
    end
    if (!item_valid) begin
      res.count = 2'd0;
    end
  end

  assign push = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= ST_START;
      line_count      <= 8'd0;
      frame_channel   <= 5'd0;
      frame_kind      <= FT_NONE;
      expected_length <= 14'd0;
      received_count  <= 14'd0;
      digit_index     <= 3'd0;
      escape_pending  <= 1'b0;
    end else if (item_valid) begin
      parse_state     <= parse_state_next;
      line_count      <= line_count_next;
      frame_channel   <= frame_channel_next;
      frame_kind      <= frame_kind_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      digit_index     <= digit_index_next;
      escape_pending  <= escape_pending_next;
    end
  end

endmodule

### hw/rtl/afp_result_fifo.sv
// Result queue that takes up to two results per cycle and gives one per transfer.
// Depends on afp_pkg.
module afp_result_fifo import afp_pkg::*; #(
  parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  push_t                         push,
  input  logic                          pop,
  output result_t                       head,
  output logic [$clog2(RESULT_DEPTH):0] fill
);

  localparam int PW = $clog2(RESULT_DEPTH);

  result_t         entries [RESULT_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill_next;
  logic [PW-1:0]   wr_ptr_second;

  assign wr_ptr_second = wr_ptr + PW'(1);
  assign head          = entries[rd_ptr];
  assign fill_next     = fill + (PW+1)'(push.count) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill_next;
    end
  end

endmodule

### hw/rtl/at_escape_frame_parser.sv
// Escape frame parser top level: input register, parse state machine and result queue.
// An accepted byte is held in the input register; the parse state machine then writes its
// results into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle unless in_stall; results leave at one per cycle unless
// out_stall; two-result bytes slow intake, as the queue stalls input when near full.
// Reset clears the parse state, empties the queue and sets the escape byte to 27.
// Depends on afp_pkg, afp_parser and afp_result_fifo.
module at_escape_frame_parser import afp_pkg::*; #(
  parameter int LINE_MAX     = LINE_MAX_DEF,
  parameter int LEN_DIGITS   = LEN_DIGITS_DEF,
  parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] result_kind,
  output logic [2:0] frame_type,
  output logic [4:0] channel_id,
  output logic [7:0] data_byte,
  output logic [7:0] line_length,
  output logic [2:0] event_code,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int PW = $clog2(RESULT_DEPTH);

  logic        item_valid;
  logic [7:0]  item_byte;
  logic [7:0]  escape_byte;
  push_t       push;
  result_t     head;
  logic [PW:0] fill;
  logic [PW+1:0] committed;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      escape_byte <= cfg_data;
    end
  end

  // A new transfer needs room for two results of the byte held plus two of its own.
  assign committed = (PW+2)'(fill) + (item_valid ? (PW+2)'(4) : (PW+2)'(2));
  assign in_stall  = committed > (PW+2)'(RESULT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_byte <= rx_byte;
    end
  end

  afp_parser #(
    .LINE_MAX   (LINE_MAX),
    .LEN_DIGITS (LEN_DIGITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_byte   (item_byte),
    .escape_byte (escape_byte),
    .push        (push)
  );

  assign out_valid = fill != '0;
  assign pop       = out_valid && !out_stall;

  afp_result_fifo #(
    .RESULT_DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .fill (fill)
  );

  assign result_kind = head.result_kind;
  assign frame_type  = head.frame_type;
  assign channel_id  = head.channel_id;
  assign data_byte   = head.data_byte;
  assign line_length = head.line_length;
  assign event_code  = head.event_code;
  assign last        = head.last;

endmodule

### tb/at_escape_frame_parser_tb.sv
// Self-checking testbench for the escape frame parser: directed and random byte traffic
// with a built-in parser prediction, random idling on both channels and a long output hold.
// Depends on afp_pkg and the at_escape_frame_parser RTL.
module at_escape_frame_parser_tb;
  import afp_pkg::*;

  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] result_kind;
  logic [2:0] frame_type;
  logic [4:0] channel_id;
  logic [7:0] data_byte;
  logic [7:0] line_length;
  logic [2:0] event_code;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  result_t pending_results[$];
  int errors = 0;
  int item_count = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_count = 0;

  parse_state_t ps;
  logic [7:0] esc_byte;
  logic [7:0] line_cnt;
  logic [4:0] frame_ch;
  logic [2:0] frame_kd;
  logic [13:0] exp_len;
  logic [13:0] rcv_cnt;
  logic [2:0] dig_idx;
  bit esc_pend;

  at_escape_frame_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .frame_type(frame_type), .channel_id(channel_id),
    .data_byte(data_byte), .line_length(line_length), .event_code(event_code),
    .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %0d",
                                  result_kind, data_byte));
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", result_kind, want.result_kind);
        check_field("frame_type", frame_type, want.frame_type);
        check_field("channel_id", channel_id, want.channel_id);
        check_field("data_byte", data_byte, want.data_byte);
        check_field("line_length", line_length, want.line_length);
        check_field("event_code", event_code, want.event_code);
        check_field("last", last, want.last);
      end
    end
  end

  // The receiver either idles at random or, on request, holds off for a fixed stretch.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_req = 1'b0;
        hold_count = 0;
      end
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  function automatic logic [4:0] channel_of(input logic [7:0] c);
    if (c >= DIGIT_0 && c <= DIGIT_9) return 5'(c - DIGIT_0);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [2:0] finish_code(input logic [2:0] kind);
    if (kind == FT_STREAM) return EV_STREAM;
    if (kind == FT_HTTP) return EV_HTTP;
    return EV_BULK;
  endfunction

  task automatic add_result(input logic [2:0] kind, input logic [2:0] ft, input logic [4:0] ch,
                            input logic [7:0] data, input logic [7:0] len,
                            input logic [2:0] ev);
    result_t r;
    r.result_kind = kind;
    r.frame_type = ft;
    r.channel_id = ch;
    r.data_byte = data;
    r.line_length = len;
    r.event_code = ev;
    r.last = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic back_to_start();
    ps = ST_START;
    line_cnt = 8'd0;
    exp_len = 14'd0;
    rcv_cnt = 14'd0;
    dig_idx = 3'd0;
    esc_pend = 1'b0;
    frame_kd = FT_NONE;
  endtask

  task automatic open_frame(input logic [2:0] kind);
    frame_kd = kind;
    ps = ST_CID;
    dig_idx = 3'd0;
    exp_len = 14'd0;
    rcv_cnt = 14'd0;
    esc_pend = 1'b0;
  endtask

  task automatic end_frame();
    add_result(KIND_EVENT, frame_kd, frame_ch, 8'd0, 8'd0, finish_code(frame_kd));
    back_to_start();
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int first_idx;
    result_t r;
    first_idx = pending_results.size();
    case (ps)
      ST_START: begin
        if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
        end else if (b == esc_byte) begin
          ps = ST_ESC;
        end else begin
          line_cnt = 8'd1;
          ps = ST_LINE;
          add_result(KIND_LBYTE, 3'd0, 5'd0, b, 8'd0, EV_NONE);
        end
      end
      ST_LINE: begin
        if (b == esc_byte) begin
          add_result(KIND_LABORT, 3'd0, 5'd0, 8'd0, line_cnt, EV_NONE);
          line_cnt = 8'd0;
          ps = ST_ESC;
        end else if (b == CH_CR || b == CH_LF) begin
          add_result(KIND_LEND, 3'd0, 5'd0, 8'd0, line_cnt, EV_NONE);
          line_cnt = 8'd0;
          ps = ST_START;
        end else if (int'(line_cnt) + 1 < LINE_MAX_DEF) begin
          line_cnt = line_cnt + 8'd1;
          add_result(KIND_LBYTE, 3'd0, 5'd0, b, 8'd0, EV_NONE);
        end
      end
      ST_ESC: begin
        if (b == CH_Z) open_frame(FT_BULK);
        else if (b == CH_H) open_frame(FT_HTTP);
        else if (b == CH_S) open_frame(FT_STREAM);
        else if (b == CH_Y) open_frame(FT_UDPB);
        else if (b == CH_U_LO || b == CH_U_UP) open_frame(FT_UDP);
        else if (b == CH_O) begin
          back_to_start();
          add_result(KIND_EVENT, 3'd0, 5'd0, 8'd0, 8'd0, EV_OK);
        end else if (b == CH_F) begin
          back_to_start();
          add_result(KIND_EVENT, 3'd0, 5'd0, 8'd0, 8'd0, EV_FAIL);
        end else begin
          back_to_start();
        end
      end
      ST_CID: begin
        frame_ch = channel_of(b);
        dig_idx = 3'd0;
        exp_len = 14'd0;
        esc_pend = 1'b0;
        if (frame_kd == FT_STREAM) ps = ST_DATA_ESC;
        else if (frame_kd == FT_UDPB || frame_kd == FT_UDP) ps = ST_ADDR;
        else ps = ST_LEN;
      end
      ST_ADDR: begin
        if (b == CH_SPACE) ps = ST_PORT;
      end
      ST_PORT: begin
        if (b == CH_TAB) begin
          dig_idx = 3'd0;
          exp_len = 14'd0;
          esc_pend = 1'b0;
          ps = (frame_kd == FT_UDP) ? ST_DATA_ESC : ST_LEN;
        end
      end
      ST_LEN: begin
        if (b < DIGIT_0 || b > DIGIT_9) begin
          back_to_start();
        end else begin
          exp_len = 14'(int'(exp_len) * 10 + int'(b - DIGIT_0));
          dig_idx = dig_idx + 3'd1;
          if (dig_idx >= LEN_DIGITS_DEF) begin
            rcv_cnt = 14'd0;
            if (exp_len == 14'd0) end_frame();
            else ps = ST_DATA_LEN;
          end
        end
      end
      ST_DATA_LEN: begin
        add_result(KIND_PAYLOAD, frame_kd, frame_ch, b, 8'd0, EV_NONE);
        rcv_cnt = rcv_cnt + 14'd1;
        if (rcv_cnt >= exp_len) end_frame();
      end
      ST_DATA_ESC: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          if (b == CH_E) begin
            end_frame();
          end else begin
            add_result(KIND_PAYLOAD, frame_kd, frame_ch, esc_byte, 8'd0, EV_NONE);
            add_result(KIND_PAYLOAD, frame_kd, frame_ch, b, 8'd0, EV_NONE);
          end
        end else if (b == esc_byte) begin
          esc_pend = 1'b1;
        end else begin
          add_result(KIND_PAYLOAD, frame_kd, frame_ch, b, 8'd0, EV_NONE);
        end
      end
      default: back_to_start();
    endcase
    if (pending_results.size() > first_idx) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_rx_byte(b);
    item_count++;
  endtask

  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
      pending_results.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_escape(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    esc_byte = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_channel();
    int v;
    v = $urandom_range(0, 24);
    if (v < 10) return DIGIT_0 + 8'(v);
    if (v < 16) return 8'h41 + 8'(v - 10);
    if (v < 22) return 8'h61 + 8'(v - 16);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
    else c = 8'($urandom_range(32, 126));
    if (c == CH_CR || c == CH_LF || c == esc_byte) c = 8'h2E;
    return c;
  endfunction

  task automatic send_line(input int n, input logic [7:0] term);
    repeat (n) send_byte(line_char());
    send_byte(term);
  endtask

  task automatic send_addr_port();
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) begin
      c = 8'($urandom_range(0, 255));
      send_byte(c == CH_SPACE ? DIGIT_0 : c);
    end
    send_byte(CH_SPACE);
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(0, 255));
      send_byte(c == CH_TAB ? DIGIT_9 : c);
    end
    send_byte(CH_TAB);
  endtask

  task automatic send_escaped_payload(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      send_byte(c);
      if (c == esc_byte) begin
        c = 8'($urandom_range(0, 255));
        send_byte(c == CH_E ? CH_F : c);
      end
    end
  endtask

  task automatic send_open_frame(input logic [7:0] letter, input logic [7:0] ch, input int n);
    send_byte(esc_byte);
    send_byte(letter);
    send_byte(ch);
    if (letter != CH_S) send_addr_port();
    send_escaped_payload(n);
    send_byte(esc_byte);
    send_byte(CH_E);
  endtask

  task automatic send_length_digits(input int len);
    send_byte(DIGIT_0 + 8'((len / 1000) % 10));
    send_byte(DIGIT_0 + 8'((len / 100) % 10));
    send_byte(DIGIT_0 + 8'((len / 10) % 10));
    send_byte(DIGIT_0 + 8'(len % 10));
  endtask

  task automatic send_length_frame(input logic [7:0] letter, input logic [7:0] ch,
                                   input int len);
    send_byte(esc_byte);
    send_byte(letter);
    send_byte(ch);
    if (letter == CH_Y) send_addr_port();
    send_length_digits(len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_line($urandom_range(0, 20), $urandom_range(0, 1) ? CH_CR : CH_LF);
    end else if (r < 38) begin
      send_open_frame(CH_S, pick_channel(), $urandom_range(0, 10));
    end else if (r < 48) begin
      send_open_frame($urandom_range(0, 1) ? CH_U_LO : CH_U_UP, pick_channel(),
                      $urandom_range(0, 8));
    end else if (r < 60) begin
      send_length_frame(CH_Z, pick_channel(), $urandom_range(0, 12));
    end else if (r < 68) begin
      send_length_frame(CH_H, pick_channel(), $urandom_range(0, 12));
    end else if (r < 76) begin
      send_length_frame(CH_Y, pick_channel(), $urandom_range(0, 8));
    end else if (r < 83) begin
      send_byte(esc_byte);
      send_byte($urandom_range(0, 1) ? CH_O : CH_F);
    end else if (r < 86) begin
      send_byte(esc_byte);
      send_byte(8'($urandom_range(0, 255)));
    end else if (r < 89) begin
      repeat ($urandom_range(1, 6)) send_byte(line_char());
      send_byte(esc_byte);
      send_byte(CH_O);
    end else if (r < 92) begin
      send_byte(esc_byte);
      send_byte(CH_Z);
      send_byte(pick_channel());
      repeat ($urandom_range(0, 3)) send_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
      send_byte(CH_SPACE);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_SPACE);
      send_byte(CH_TAB);
      send_byte(esc_byte);
      send_byte(CH_E);
    end
  endtask

  task automatic test_idle_and_lines();
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_NUL);
    send_byte(8'h78);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_NUL);
    send_byte(8'h80);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_line(2, CH_LF);
  endtask

  // Both sides run without idling for the whole of the long line.
  task automatic test_long_line();
    quiet = 1'b1;
    for (int i = 0; i < 260; i++) send_byte(8'h61 + 8'(i % 26));
    send_byte(CH_CR);
    quiet = 1'b0;
  endtask

  task automatic test_status_escapes();
    send_byte(esc_byte);
    send_byte(CH_O);
    send_byte(esc_byte);
    send_byte(CH_F);
    send_byte(esc_byte);
    send_byte(8'h71);
    send_line(1, CH_LF);
  endtask

  task automatic test_line_abandon();
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(esc_byte);
    send_byte(CH_O);
  endtask

  task automatic test_escape_frames();
    send_byte(esc_byte);
    send_byte(CH_S);
    send_byte(8'h37);
    send_byte(8'h68);
    send_byte(esc_byte);
    send_byte(8'h78);
    send_byte(esc_byte);
    send_byte(CH_E);
    send_open_frame(CH_U_LO, 8'h66, 2);
    send_open_frame(CH_U_UP, 8'h47, 0);
  endtask

  task automatic test_length_frames();
    send_length_frame(CH_Z, 8'h33, 0);
    send_byte(esc_byte);
    send_byte(CH_H);
    send_byte(8'h61);
    send_length_digits(3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(esc_byte);
    send_length_frame(CH_Y, 8'h62, 2);
    send_byte(esc_byte);
    send_byte(CH_Z);
    send_byte(8'h31);
    send_byte(DIGIT_0);
    send_byte(8'h31);
    send_byte(8'h78);
  endtask

  task automatic test_random_traffic();
    int first_item;
    bit hold_done;
    first_item = item_count;
    hold_done = 1'b0;
    while (item_count < first_item + RANDOM_ITEMS) begin
      if (!hold_done && item_count - first_item >= 10) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      send_random_sequence();
    end
  endtask

  task automatic test_escape_settings();
    logic [7:0] values[4];
    int first_item;
    values[0] = 8'hFF;
    values[1] = 8'h00;
    values[2] = 8'($urandom_range(128, 254));
    values[3] = ESCAPE_RESET;
    foreach (values[i]) begin
      settle();
      write_escape(values[i]);
      first_item = item_count;
      while (item_count < first_item + 8) send_random_sequence();
    end
  endtask

  initial begin
    esc_byte = ESCAPE_RESET;
    frame_ch = 5'd0;
    back_to_start();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_and_lines();
    test_long_line();
    test_status_escapes();
    test_line_abandon();
    test_escape_frames();
    test_length_frames();
    test_random_traffic();
    test_escape_settings();
    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
